// File: hdl/ltm_pkg.sv
// ----------------------------------------------------------------------------
// ltm_pkg
// Shared sizes, types and helpers for the truth-table merge block.
// ----------------------------------------------------------------------------
package ltm_pkg;

  localparam int INPUT_CAP  = 6;
  localparam int ID_BITS    = 10;
  localparam int CNT_W      = 3;
  localparam int MASK_W     = 1 << INPUT_CAP;
  localparam int SIG_W      = INPUT_CAP * ID_BITS;
  localparam int LIST_SLOTS = 2 * INPUT_CAP + 1;
  localparam int POS_W      = $clog2(LIST_SLOTS);
  localparam int NUM_W      = $clog2(LIST_SLOTS + 1);
  localparam int IDX_W      = $clog2(INPUT_CAP);
  localparam int PCNT_W     = $clog2(INPUT_CAP + 1);

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // register index, taken from paddr above the byte offset
  localparam logic REG_MAX_INPUTS = 1'b0;
  localparam logic [CNT_W-1:0] MAX_INPUTS_RST = CNT_W'(INPUT_CAP);

  typedef logic [ID_BITS-1:0] sig_id_t;
  typedef logic [POS_W-1:0]   pos_t;

  typedef struct packed {
    logic [NUM_W-1:0]       num;
    logic [CNT_W-1:0]       dcnt;
    logic [CNT_W-1:0]       scnt;
    pos_t                   data_pos;
    pos_t                   alt_pos;
    pos_t [INPUT_CAP-1:0]   sel_pos;
    logic [SIG_W-1:0]       sigs;
  } place_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
    return (c > CNT_W'(INPUT_CAP)) ? CNT_W'(INPUT_CAP) : c;
  endfunction

  // bit of a table row number at a list position; positions past the cap read zero
  function automatic logic pick_bit(input logic [INPUT_CAP-1:0] row, input pos_t pos);
    return (pos < POS_W'(INPUT_CAP)) ? row[pos[IDX_W-1:0]] : 1'b0;
  endfunction

endpackage

// File: hdl/ltm_place.sv
// ----------------------------------------------------------------------------
// ltm_place
// Builds the merged input list: positions of data, select and alternative
// signals, the merged count and the packed signal ids.
// ----------------------------------------------------------------------------
module ltm_place import ltm_pkg::*; (
  input  logic [CNT_W-1:0]   data_count,
  input  logic [SIG_W-1:0]   data_signals,
  input  logic [CNT_W-1:0]   select_count,
  input  logic [SIG_W-1:0]   select_signals,
  input  logic               alt_is_signal,
  input  sig_id_t            alt_signal,
  output place_t             place_o
);

  logic [CNT_W-1:0]          dc;
  logic [CNT_W-1:0]          sc;
  sig_id_t [INPUT_CAP-1:0]   d_id;
  sig_id_t [INPUT_CAP-1:0]   s_id;
  logic [INPUT_CAP-1:0]      s_new;
  logic [INPUT_CAP-1:0]      s_dfound;
  logic [IDX_W-1:0]          s_dk  [INPUT_CAP];
  logic [IDX_W-1:0]          s_rep [INPUT_CAP];
  logic [PCNT_W-1:0]         pcnt;
  logic [PCNT_W-1:0]         above;
  pos_t [INPUT_CAP-1:0]      pre_pos;
  pos_t [INPUT_CAP-1:0]      fin_pos;
  logic                      a_dfound;
  logic                      a_sfound;
  logic                      a_new;
  logic [IDX_W-1:0]          a_dk;
  logic [IDX_W-1:0]          a_si;
  pos_t                      alt_pre;
  pos_t                      shift;
  pos_t                      dpos;
  sig_id_t                   slot;
  logic [SIG_W-1:0]          sigs;

  always_comb begin
    dc = clamp_count(data_count);
    sc = clamp_count(select_count);
    for (int k = 0; k < INPUT_CAP; k++) begin
      d_id[k] = data_signals[k*ID_BITS +: ID_BITS];
      s_id[k] = select_signals[k*ID_BITS +: ID_BITS];
    end

    // classify each select: matches data, repeats an earlier select, or new
    for (int j = 0; j < INPUT_CAP; j++) begin
      s_dfound[j] = 1'b0;
      s_dk[j]     = '0;
      for (int k = 0; k < INPUT_CAP; k++) begin
        if (CNT_W'(k) < dc && s_id[j] == d_id[k]) begin
          s_dfound[j] = 1'b1;
          s_dk[j]     = IDX_W'(k);
        end
      end
      s_rep[j] = IDX_W'(j);
      for (int i = INPUT_CAP - 1; i >= 0; i--) begin
        if (i < j && s_id[i] == s_id[j]) begin
          s_rep[j] = IDX_W'(i);
        end
      end
      s_new[j] = (CNT_W'(j) < sc) && !s_dfound[j] && (s_rep[j] == IDX_W'(j));
    end

    pcnt = '0;
    for (int j = 0; j < INPUT_CAP; j++) begin
      pcnt = pcnt + PCNT_W'(s_new[j]);
    end

    // new selects sit in reverse order below the data signals
    for (int j = 0; j < INPUT_CAP; j++) begin
      above = '0;
      for (int i = 0; i < INPUT_CAP; i++) begin
        if (s_new[i] && IDX_W'(i) > s_rep[j]) begin
          above = above + PCNT_W'(1);
        end
      end
      if (s_dfound[j]) begin
        pre_pos[j] = POS_W'(pcnt) + POS_W'(s_dk[j]);
      end else begin
        pre_pos[j] = POS_W'(above);
      end
    end

    a_dfound = 1'b0;
    a_dk     = '0;
    a_sfound = 1'b0;
    a_si     = '0;
    for (int k = 0; k < INPUT_CAP; k++) begin
      if (CNT_W'(k) < dc && alt_signal == d_id[k]) begin
        a_dfound = 1'b1;
        a_dk     = IDX_W'(k);
      end
      if (CNT_W'(k) < sc && alt_signal == s_id[k]) begin
        a_sfound = 1'b1;
        a_si     = IDX_W'(k);
      end
    end
    a_new = alt_is_signal && !a_dfound && !a_sfound;
    if (a_dfound) begin
      alt_pre = POS_W'(pcnt) + POS_W'(a_dk);
    end else if (a_sfound) begin
      alt_pre = pre_pos[a_si];
    end else begin
      alt_pre = '0;
    end

    shift = POS_W'(a_new);
    dpos  = POS_W'(pcnt) + shift;
    for (int j = 0; j < INPUT_CAP; j++) begin
      fin_pos[j] = pre_pos[j] + shift;
    end

    // gather ids slot by slot; every slot has at most one owner
    for (int p = 0; p < INPUT_CAP; p++) begin
      slot = '0;
      if (a_new && p == 0) begin
        slot = alt_signal;
      end
      for (int j = 0; j < INPUT_CAP; j++) begin
        if (s_new[j] && fin_pos[j] == POS_W'(p)) begin
          slot = slot | s_id[j];
        end
      end
      for (int k = 0; k < INPUT_CAP; k++) begin
        if (CNT_W'(k) < dc && (dpos + POS_W'(k)) == POS_W'(p)) begin
          slot = slot | d_id[k];
        end
      end
      sigs[p*ID_BITS +: ID_BITS] = slot;
    end

    place_o.num      = NUM_W'(dc) + NUM_W'(pcnt) + NUM_W'(a_new);
    place_o.dcnt     = dc;
    place_o.scnt     = sc;
    place_o.data_pos = dpos;
    place_o.alt_pos  = a_new ? '0 : alt_pre;
    place_o.sel_pos  = fin_pos;
    place_o.sigs     = sigs;
  end

endmodule

// File: hdl/ltm_table.sv
// ----------------------------------------------------------------------------
// ltm_table
// Evaluates every row of the merged truth table from the placed input list
// and applies the input-count limit.
// ----------------------------------------------------------------------------
module ltm_table import ltm_pkg::*; (
  input  place_t              place_i,
  input  logic [MASK_W-1:0]   data_mask,
  input  logic [MASK_W-1:0]   select_mask,
  input  logic                select_invert,
  input  logic                alt_is_signal,
  input  logic                alt_constant,
  input  logic [CNT_W-1:0]    max_inputs,
  output logic                merge_ok,
  output logic [MASK_W-1:0]   merged_mask,
  output logic [CNT_W-1:0]    merged_count,
  output logic [SIG_W-1:0]    merged_signals
);

  logic [CNT_W-1:0]      limit;
  logic                  fits;
  logic [INPUT_CAP-1:0]  dmask;
  logic [INPUT_CAP-1:0]  row;
  logic [INPUT_CAP-1:0]  sidx;
  logic [INPUT_CAP-1:0]  didx;
  logic                  choose_alt;
  logic                  row_bit;
  logic [MASK_W-1:0]     mask;

  always_comb begin
    limit = clamp_count(max_inputs);
    fits  = place_i.num <= NUM_W'(limit);
    dmask = ~({INPUT_CAP{1'b1}} << place_i.dcnt);

    for (int j = 0; j < MASK_W; j++) begin
      row = INPUT_CAP'(j);
      for (int k = 0; k < INPUT_CAP; k++) begin
        sidx[k] = (CNT_W'(k) < place_i.scnt) ? pick_bit(row, place_i.sel_pos[k]) : 1'b0;
      end
      didx       = (row >> place_i.data_pos) & dmask;
      choose_alt = select_mask[sidx] ^ select_invert;
      if (choose_alt) begin
        row_bit = alt_is_signal ? pick_bit(row, place_i.alt_pos) : alt_constant;
      end else begin
        row_bit = data_mask[didx];
      end
      // drop rows past the merged table size
      mask[j] = row_bit && ((row >> place_i.num) == '0);
    end

    merge_ok       = fits;
    merged_mask    = fits ? mask : '0;
    merged_count   = fits ? CNT_W'(place_i.num) : '0;
    merged_signals = fits ? place_i.sigs : '0;
  end

endmodule

// File: hdl/lut_truth_table_merge.sv
// ----------------------------------------------------------------------------
// lut_truth_table_merge
// Merges a data lookup table, a select table and an alternative value into
// one table computing (select ^ invert) ? alternative : data.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall   data and select tables, alt
//   out_      output     out_valid / out_stall merge_ok, merged table
//   p*        config     psel/penable/pready   max_inputs at byte addresses 0 to 3
//
// The path runs through an input register, one combinational merge pass,
// and the result register. One item is taken every cycle while in_stall is low.
// Reset (rst_n low, synchronous) empties both registers and sets
// max_inputs to 6.
// A stalled result holds in the result register while the input register
// still takes an item; in_stall is high only when both registers are full
// and out_stall is high.
// ----------------------------------------------------------------------------
module lut_truth_table_merge import ltm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MASK_W-1:0]     in_data_mask,
  input  logic [CNT_W-1:0]      in_data_count,
  input  logic [SIG_W-1:0]      in_data_signals,
  input  logic [MASK_W-1:0]     in_select_mask,
  input  logic [CNT_W-1:0]      in_select_count,
  input  logic [SIG_W-1:0]      in_select_signals,
  input  logic                  in_select_invert,
  input  logic                  in_alt_is_signal,
  input  logic [ID_BITS-1:0]    in_alt_signal,
  input  logic                  in_alt_constant,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_merge_ok,
  output logic [MASK_W-1:0]     out_merged_mask,
  output logic [CNT_W-1:0]      out_merged_count,
  output logic [SIG_W-1:0]      out_merged_signals,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                  s1_valid_r, s1_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]      max_inputs_r, max_inputs_nxt;

  logic [MASK_W-1:0]     data_mask_r;
  logic [CNT_W-1:0]      data_count_r;
  logic [SIG_W-1:0]      data_signals_r;
  logic [MASK_W-1:0]     select_mask_r;
  logic [CNT_W-1:0]      select_count_r;
  logic [SIG_W-1:0]      select_signals_r;
  logic                  select_invert_r;
  logic                  alt_is_signal_r;
  sig_id_t               alt_signal_r;
  logic                  alt_constant_r;

  logic                  merge_ok_r;
  logic [MASK_W-1:0]     merged_mask_r;
  logic [CNT_W-1:0]      merged_count_r;
  logic [SIG_W-1:0]      merged_signals_r;

  logic                  out_adv;
  logic                  in_take;
  logic                  reg_hit;
  logic                  cfg_wr;

  place_t                place;
  logic                  merge_ok_c;
  logic [MASK_W-1:0]     merged_mask_c;
  logic [CNT_W-1:0]      merged_count_c;
  logic [SIG_W-1:0]      merged_signals_c;

  // result register frees up when empty or when its transfer completes
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  assign reg_hit        = paddr[CFG_ADDR_W-1:2] == REG_MAX_INPUTS;
  assign cfg_wr         = psel && penable && pwrite && pready;
  assign max_inputs_nxt = (cfg_wr && reg_hit) ? pwdata[CNT_W-1:0] : max_inputs_r;
  assign prdata         = reg_hit ? CFG_DATA_W'(max_inputs_r) : '0;
  assign pready         = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      max_inputs_r <= MAX_INPUTS_RST;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      max_inputs_r <= max_inputs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      data_mask_r      <= in_data_mask;
      data_count_r     <= in_data_count;
      data_signals_r   <= in_data_signals;
      select_mask_r    <= in_select_mask;
      select_count_r   <= in_select_count;
      select_signals_r <= in_select_signals;
      select_invert_r  <= in_select_invert;
      alt_is_signal_r  <= in_alt_is_signal;
      alt_signal_r     <= in_alt_signal;
      alt_constant_r   <= in_alt_constant;
    end
  end

  ltm_place u_place (
    .data_count     (data_count_r),
    .data_signals   (data_signals_r),
    .select_count   (select_count_r),
    .select_signals (select_signals_r),
    .alt_is_signal  (alt_is_signal_r),
    .alt_signal     (alt_signal_r),
    .place_o        (place)
  );

  ltm_table u_table (
    .place_i        (place),
    .data_mask      (data_mask_r),
    .select_mask    (select_mask_r),
    .select_invert  (select_invert_r),
    .alt_is_signal  (alt_is_signal_r),
    .alt_constant   (alt_constant_r),
    .max_inputs     (max_inputs_r),
    .merge_ok       (merge_ok_c),
    .merged_mask    (merged_mask_c),
    .merged_count   (merged_count_c),
    .merged_signals (merged_signals_c)
  );

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      merge_ok_r       <= merge_ok_c;
      merged_mask_r    <= merged_mask_c;
      merged_count_r   <= merged_count_c;
      merged_signals_r <= merged_signals_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_merge_ok       = merge_ok_r;
  assign out_merged_mask    = merged_mask_r;
  assign out_merged_count   = merged_count_r;
  assign out_merged_signals = merged_signals_r;

  // a failed merge carries no table
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !merge_ok_r |->
      merged_count_r == '0 && merged_mask_r == '0 && merged_signals_r == '0)
    else $error("failed merge with nonzero result fields");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && merge_ok_r |-> merged_count_r <= clamp_count(max_inputs_r))
    else $error("merged count above the configured limit");

  a_mask_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (merged_mask_r >> (MASK_W'(1) << merged_count_r)) == '0)
    else $error("merged mask bits set past the table size");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled while a register is free");

endmodule
